[src/bpc_pkg.sv]
// Package for the button press classifier: action codes, register
// indexes and the state and configuration structs shared by all modules.
// No dependencies.
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgAddrW = 3;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_IDLE  = 2'd1,
    ACT_SHORT = 2'd2,
    ACT_LONG  = 2'd3
  } action_e;

  localparam logic [CfgAddrW-1:0] CFG_BOUNCE = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_SHORT  = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_LONG   = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_IDLE   = 3'd3;

  localparam logic [TimeW-1:0] BounceRst = 32'd50;
  localparam logic [TimeW-1:0] ShortRst  = 32'd100;
  localparam logic [TimeW-1:0] LongRst   = 32'd1000;
  localparam logic [TimeW-1:0] IdleRst   = 32'd5000;

  typedef struct packed {
    logic             pressed;
    logic             ready;
    logic [TimeW-1:0] last_edge_ms;
    logic [TimeW-1:0] press_length;
  } state_t;

  typedef struct packed {
    logic [TimeW-1:0] bounce_period;
    logic [TimeW-1:0] short_period;
    logic [TimeW-1:0] long_period;
    logic [TimeW-1:0] idle_period;
  } cfg_t;

endpackage

[src/bpc_core.sv]
// Classification logic for one beat: computes the next button state and
// the reported action from the current state, the registers and the beat.
// Depends on bpc_pkg.
`timescale 1ns / 1ps

module bpc_core (
  input  logic                     mode_i,
  input  logic [bpc_pkg::TimeW-1:0] now_ms_i,
  input  bpc_pkg::state_t          state_i,
  input  bpc_pkg::cfg_t            cfg_i,
  output bpc_pkg::state_t          state_o,
  output bpc_pkg::action_e         action_o
);

  logic [bpc_pkg::TimeW-1:0] since;
  bpc_pkg::action_e          kind;
  logic                      ready_mid;

  assign since = now_ms_i - state_i.last_edge_ms;

  always_comb begin
    state_o   = state_i;
    action_o  = bpc_pkg::ACT_NONE;
    kind      = bpc_pkg::ACT_NONE;
    ready_mid = state_i.ready;
    if (mode_i) begin
      if (since >= cfg_i.bounce_period) begin
        state_o.pressed      = ~state_i.pressed;
        state_o.last_edge_ms = now_ms_i;
        if (!state_i.pressed) begin
          state_o.ready        = 1'b1;
          state_o.press_length = '0;
        end else begin
          state_o.press_length = since;
        end
      end
    end else begin
      if (state_i.pressed) begin
        if (since >= cfg_i.long_period) begin
          kind                 = bpc_pkg::ACT_LONG;
          state_o.last_edge_ms = now_ms_i;
        end
      end else if (since > cfg_i.idle_period) begin
        kind      = bpc_pkg::ACT_IDLE;
        ready_mid = 1'b1;
      end else if (state_i.press_length > cfg_i.short_period) begin
        kind = bpc_pkg::ACT_SHORT;
      end
      state_o.ready = ready_mid;
      if (ready_mid && (kind != bpc_pkg::ACT_NONE)) begin
        action_o      = kind;
        state_o.ready = 1'b0;
        if ((kind == bpc_pkg::ACT_IDLE) || (kind == bpc_pkg::ACT_LONG)) begin
          state_o.last_edge_ms = now_ms_i;
        end
      end
    end
  end

endmodule

[src/button_press_classifier_top.sv]
// Top level of the button press classifier: input register, state and
// configuration registers, and the result register around bpc_core.
// Depends on bpc_pkg and bpc_core.
//
// Each input beat carries mode_i (0 poll tick, 1 button edge) and a
// free-running millisecond timestamp now_ms_i. Every accepted beat yields
// exactly one result beat on action_o: an edge beat always reports none,
// a poll beat reports none, idle, short press or long press.
// A beat is accepted when in_valid_i is high and in_stall_o is low; a
// result is taken when out_valid_o is high and out_stall_i is low.
// The accepted beat sits in the input register, where the state is read
// and updated, and its result then passes into the result register, from
// which it is taken.
// One beat is accepted every cycle while the output is not stalled; the
// single pass through one subtract and a few compares sets that rate.
// When the receiver stalls, the result register holds, then the input
// register fills and in_stall_o rises until the result is taken.
// Reset clears the button state and loads the default periods (50, 100,
// 1000, 5000 ms). The user must write the registers through cfg_we_i only
// while idle (not enforced by the block); indexes above three are ignored.
`timescale 1ns / 1ps

module button_press_classifier_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [bpc_pkg::TimeW-1:0]     now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    action_o,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [bpc_pkg::TimeW-1:0]     cfg_wdata_i
);

  logic                      s1_valid_q;
  logic                      s1_mode_q;
  logic [bpc_pkg::TimeW-1:0] s1_now_q;
  logic                      out_valid_q;
  bpc_pkg::action_e          out_action_q;
  bpc_pkg::state_t           state_q;
  bpc_pkg::state_t           state_d;
  bpc_pkg::cfg_t             cfg_q;
  bpc_pkg::action_e          core_action;
  logic                      s1_adv;
  logic                      s1_fire;
  logic                      in_fire;

  assign s1_adv     = ~out_valid_q | ~out_stall_i;
  assign s1_fire    = s1_valid_q & s1_adv;
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_fire    = in_valid_i & ~in_stall_o;

  assign out_valid_o = out_valid_q;
  assign action_o    = out_action_q;

  bpc_core u_core (
    .mode_i   (s1_mode_q),
    .now_ms_i (s1_now_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .action_o (core_action)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q <= mode_i;
      s1_now_q  <= now_ms_i;
    end
    if (s1_fire) begin
      out_action_q <= core_action;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bounce_period <= bpc_pkg::BounceRst;
      cfg_q.short_period  <= bpc_pkg::ShortRst;
      cfg_q.long_period   <= bpc_pkg::LongRst;
      cfg_q.idle_period   <= bpc_pkg::IdleRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bpc_pkg::CFG_BOUNCE: cfg_q.bounce_period <= cfg_wdata_i;
        bpc_pkg::CFG_SHORT:  cfg_q.short_period  <= cfg_wdata_i;
        bpc_pkg::CFG_LONG:   cfg_q.long_period   <= cfg_wdata_i;
        bpc_pkg::CFG_IDLE:   cfg_q.idle_period   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // An edge beat never produces an action.
  a_edge_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_mode_q |=> out_action_q == bpc_pkg::ACT_NONE)
    else $error("edge beat produced an action");

  // Reporting an action disarms the block.
  a_report_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (core_action != bpc_pkg::ACT_NONE) |=> !state_q.ready)
    else $error("ready still set after a report");

  // An accepted press arms the block.
  a_press_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_mode_q && !state_q.pressed && state_d.pressed |=> state_q.ready)
    else $error("press did not arm the block");

  // The button state only moves when a beat passes through.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(state_q))
    else $error("state changed without a beat");

endmodule
